/* hdl/bbm_pkg.sv */
package bbm_pkg;

    // Converter operating modes as reported on the result channel.
    typedef enum logic [1:0] {
        MODE_BUCKBOOST = 2'd0,
        MODE_BUCK      = 2'd1,
        MODE_BOOST     = 2'd2,
        MODE_SHUTDOWN  = 2'd3
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_BAND_CENTER     = 3'd0,
        CFG_BAND_HYSTERESIS = 3'd1,
        CFG_OVER_VOLTAGE    = 3'd2,
        CFG_BUCK_DUTY_MAX   = 3'd3,
        CFG_BUCK_DUTY_MIN   = 3'd4,
        CFG_BOOST_DUTY_MAX  = 3'd5,
        CFG_BOOST_DUTY_MIN  = 3'd6
    } t_cfg_index;

    // Reset values of the configuration registers.
    localparam logic [15:0] BAND_CENTER_RST     = 16'd1000;
    localparam logic [15:0] BAND_HYSTERESIS_RST = 16'd200;
    localparam logic [15:0] OVER_VOLTAGE_RST    = 16'd60000;
    localparam logic [15:0] BUCK_DUTY_MAX_RST   = 16'd30000;
    localparam logic [15:0] BUCK_DUTY_MIN_RST   = 16'd1000;
    localparam logic [15:0] BOOST_DUTY_MAX_RST  = 16'd30000;
    localparam logic [15:0] BOOST_DUTY_MIN_RST  = 16'd1000;

    // Current configuration as seen by the control logic.
    typedef struct packed {
        logic [15:0] band_center;
        logic [15:0] band_hysteresis;
        logic [15:0] over_voltage_limit;
        logic [15:0] buck_duty_max;
        logic [15:0] buck_duty_min;
        logic [15:0] boost_duty_max;
        logic [15:0] boost_duty_min;
    } t_cfg;

    // One tick's voltage samples.
    typedef struct packed {
        logic [15:0] vin_now;
        logic [15:0] vout_now;
        logic [15:0] vin_mean;
        logic [15:0] vout_goal;
    } t_sample;

    // One result item.
    typedef struct packed {
        t_mode       mode;
        logic        drive_enable;
        logic        compares_valid;
        logic [15:0] buck_compare;
        logic [15:0] boost_compare;
        logic [15:0] adc_trigger_early;
        logic [15:0] adc_trigger_late;
        logic [15:0] duty_value;
    } t_result;

endpackage

/* hdl/buck_boost_mode_duty_controller_unit.sv */
// Four-switch buck-boost mode and duty controller, one input item per PWM tick.
// Input channel: i_in_valid / o_in_ready with the four voltage samples in mV.
// Result channel: o_out_valid / i_out_ready with mode, enables, timer compares
// and the duty count held after the tick.
// Configuration channel: i_cfg_valid / o_cfg_ready, always ready; i_cfg_index
// selects one of seven 16-bit registers, indexes beyond them are ignored.
// An accepted item passes through the input register, two stages of the constant
// divider for |error| / STEP_DIVISOR, then the result register that also updates
// mode, band and duty.
// Throughput: one item per cycle while the receiver is ready; the mode and duty
// feedback closes within the last stage, so consecutive items need no spacing.
// Reset: mode is shutdown, duty zero, band at the reset band center, all
// configuration registers at their reset values, no item in flight.
// When the receiver stalls, items stay in their stages and o_in_ready drops
// only once every stage is full.
module buck_boost_mode_duty_controller_unit #(
    parameter int PERIOD_COUNT = 32767,
    parameter int STEP_DIVISOR = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_vin_now,
    input  logic [15:0] i_vout_now,
    input  logic [15:0] i_vin_mean,
    input  logic [15:0] i_vout_goal,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_mode,
    output logic        o_drive_enable,
    output logic        o_compares_valid,
    output logic [15:0] o_buck_compare,
    output logic [15:0] o_boost_compare,
    output logic [15:0] o_adc_trigger_early,
    output logic [15:0] o_adc_trigger_late,
    output logic [15:0] o_duty_value
);

    bbm_pkg::t_cfg      w_cfg;
    bbm_pkg::t_sample   w_in_sample;
    bbm_pkg::t_sample   w_div_sample;
    logic [15:0]        w_div_step;
    logic               w_div_valid;
    logic               w_core_ready;
    bbm_pkg::t_result   w_result;

    assign o_cfg_ready = 1'b1;

    bbm_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign w_in_sample.vin_now   = i_vin_now;
    assign w_in_sample.vout_now  = i_vout_now;
    assign w_in_sample.vin_mean  = i_vin_mean;
    assign w_in_sample.vout_goal = i_vout_goal;

    bbm_step_div #(
        .STEP_DIVISOR (STEP_DIVISOR)
    ) u_step_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_sample (w_in_sample),
        .o_valid  (w_div_valid),
        .i_ready  (w_core_ready),
        .o_sample (w_div_sample),
        .o_step   (w_div_step)
    );

    bbm_ctrl_core #(
        .PERIOD_COUNT (PERIOD_COUNT)
    ) u_ctrl_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_div_valid),
        .o_ready  (w_core_ready),
        .i_sample (w_div_sample),
        .i_step   (w_div_step),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (w_result)
    );

    assign o_mode              = w_result.mode;
    assign o_drive_enable      = w_result.drive_enable;
    assign o_compares_valid    = w_result.compares_valid;
    assign o_buck_compare      = w_result.buck_compare;
    assign o_boost_compare     = w_result.boost_compare;
    assign o_adc_trigger_early = w_result.adc_trigger_early;
    assign o_adc_trigger_late  = w_result.adc_trigger_late;
    assign o_duty_value        = w_result.duty_value;

endmodule

/* hdl/bbm_cfg_regs.sv */
module bbm_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output bbm_pkg::t_cfg       o_cfg
);

    bbm_pkg::t_cfg r_cfg;
    bbm_pkg::t_cfg n_cfg;

    // Decode the register index; indexes beyond the list are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && i_cfg_ready) begin
            case (bbm_pkg::t_cfg_index'(i_cfg_index))
                bbm_pkg::CFG_BAND_CENTER:     n_cfg.band_center        = i_cfg_data;
                bbm_pkg::CFG_BAND_HYSTERESIS: n_cfg.band_hysteresis    = i_cfg_data;
                bbm_pkg::CFG_OVER_VOLTAGE:    n_cfg.over_voltage_limit = i_cfg_data;
                bbm_pkg::CFG_BUCK_DUTY_MAX:   n_cfg.buck_duty_max      = i_cfg_data;
                bbm_pkg::CFG_BUCK_DUTY_MIN:   n_cfg.buck_duty_min      = i_cfg_data;
                bbm_pkg::CFG_BOOST_DUTY_MAX:  n_cfg.boost_duty_max     = i_cfg_data;
                bbm_pkg::CFG_BOOST_DUTY_MIN:  n_cfg.boost_duty_min     = i_cfg_data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    // Register file with reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_center        <= bbm_pkg::BAND_CENTER_RST;
            r_cfg.band_hysteresis    <= bbm_pkg::BAND_HYSTERESIS_RST;
            r_cfg.over_voltage_limit <= bbm_pkg::OVER_VOLTAGE_RST;
            r_cfg.buck_duty_max      <= bbm_pkg::BUCK_DUTY_MAX_RST;
            r_cfg.buck_duty_min      <= bbm_pkg::BUCK_DUTY_MIN_RST;
            r_cfg.boost_duty_max     <= bbm_pkg::BOOST_DUTY_MAX_RST;
            r_cfg.boost_duty_min     <= bbm_pkg::BOOST_DUTY_MIN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/bbm_step_div.sv */
module bbm_step_div #(
    parameter int STEP_DIVISOR = 100
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  bbm_pkg::t_sample    i_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output bbm_pkg::t_sample    o_sample,
    output logic [15:0]         o_step
);

    // A divisor of zero behaves as one.
    localparam int          DIV_EFF = (STEP_DIVISOR == 0) ? 1 : STEP_DIVISOR;
    localparam logic [15:0] DIV_W   = 16'(DIV_EFF);
    // Truncated reciprocal scaled by 2^16; the quotient estimate is low by at most one.
    localparam logic [16:0] RECIP   = 17'(65536 / DIV_EFF);

    logic               r_v0, r_v1, r_v2;
    logic               w_en0, w_en1, w_en2;
    bbm_pkg::t_sample   r_s0, r_s1, r_s2;
    logic [15:0]        r_err1;
    logic [15:0]        r_q1;
    logic [15:0]        r_step2;
    logic [15:0]        w_err;
    logic [32:0]        w_prod1;
    logic [31:0]        w_prod2;
    logic [15:0]        w_rem;
    logic [15:0]        w_step;

    // Each stage moves when it is empty or its successor moves.
    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign w_en0   = !r_v0 || w_en1;
    assign o_ready = w_en0;

    // Stage 1: regulation error magnitude and quotient estimate.
    assign w_err   = (r_s0.vout_now > r_s0.vout_goal) ? r_s0.vout_now - r_s0.vout_goal
                                                      : r_s0.vout_goal - r_s0.vout_now;
    assign w_prod1 = 33'(w_err) * 33'(RECIP);

    // Stage 2: one correction step on the quotient.
    assign w_prod2 = 32'(r_q1) * 32'(DIV_W);
    assign w_rem   = r_err1 - w_prod2[15:0];
    assign w_step  = (w_rem >= DIV_W) ? r_q1 + 16'd1 : r_q1;

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en0) begin
                r_v0 <= i_valid;
            end
            if (w_en1) begin
                r_v1 <= r_v0;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            r_s0 <= i_sample;
        end
        if (w_en1) begin
            r_s1   <= r_s0;
            r_err1 <= w_err;
            r_q1   <= w_prod1[31:16];
        end
        if (w_en2) begin
            r_s2    <= r_s1;
            r_step2 <= w_step;
        end
    end

    assign o_valid  = r_v2;
    assign o_sample = r_s2;
    assign o_step   = r_step2;

endmodule

/* hdl/bbm_ctrl_core.sv */
module bbm_ctrl_core #(
    parameter int PERIOD_COUNT = 32767
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bbm_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  bbm_pkg::t_sample    i_sample,
    input  logic [15:0]         i_step,
    output logic                o_valid,
    input  logic                i_ready,
    output bbm_pkg::t_result    o_result
);

    localparam logic [15:0] PERIOD_W    = 16'(PERIOD_COUNT);
    localparam logic [15:0] PERIOD_NEXT = 16'(PERIOD_COUNT + 1);

    bbm_pkg::t_mode     r_mode, n_mode;
    logic [15:0]        r_band, n_band;
    logic [15:0]        r_duty, n_duty;
    logic               r_out_valid;
    bbm_pkg::t_result   r_res, n_res;
    logic               w_en;

    // The result register takes a new item when empty or being drained.
    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    // Mode choice, over-voltage shutdown, duty update and compare generation.
    always_comb begin
        logic [15:0] v_narrow;
        logic [16:0] v_wide_sum;
        logic [15:0] v_wide;
        logic [15:0] v_diff;
        logic [16:0] v_duty_sum;
        logic [15:0] v_duty;
        logic [15:0] v_hi;
        logic [15:0] v_lo;
        logic        v_ov;

        v_narrow   = (i_cfg.band_center > i_cfg.band_hysteresis)
                   ? i_cfg.band_center - i_cfg.band_hysteresis : 16'd0;
        v_wide_sum = {1'b0, i_cfg.band_center} + {1'b0, i_cfg.band_hysteresis};
        v_wide     = v_wide_sum[16] ? 16'hFFFF : v_wide_sum[15:0];
        v_diff     = (i_sample.vin_mean > i_sample.vout_goal)
                   ? i_sample.vin_mean - i_sample.vout_goal
                   : i_sample.vout_goal - i_sample.vin_mean;

        n_mode = r_mode;
        n_band = r_band;
        n_duty = r_duty;

        // Hysteretic band decision; exactly on the edge keeps mode and band.
        if ({1'b0, i_sample.vout_goal} > ({1'b0, i_sample.vin_mean} + {1'b0, r_band})) begin
            n_mode = bbm_pkg::MODE_BOOST;
            n_band = v_narrow;
        end else if (({1'b0, i_sample.vout_goal} + {1'b0, r_band})
                     < {1'b0, i_sample.vin_mean}) begin
            n_mode = bbm_pkg::MODE_BUCK;
            n_band = v_narrow;
        end else if (v_diff < r_band) begin
            n_mode = bbm_pkg::MODE_BUCKBOOST;
            n_band = v_wide;
        end

        v_ov = (i_sample.vin_now >= i_cfg.over_voltage_limit)
            || (i_sample.vout_now >= i_cfg.over_voltage_limit);
        if (v_ov) begin
            n_mode = bbm_pkg::MODE_SHUTDOWN;
            n_duty = 16'd0;
        end

        // Saturating duty step toward the target.
        v_duty_sum = {1'b0, r_duty} + {1'b0, i_step};
        if (i_sample.vout_now < i_sample.vout_goal) begin
            v_duty = v_duty_sum[16] ? 16'hFFFF : v_duty_sum[15:0];
        end else if (i_sample.vout_now > i_sample.vout_goal) begin
            v_duty = (r_duty > i_step) ? r_duty - i_step : 16'd0;
        end else begin
            v_duty = r_duty;
        end

        // Mode-dependent clamp; crossed limits resolve toward the maximum above min.
        v_hi = (n_mode == bbm_pkg::MODE_BUCK) ? i_cfg.buck_duty_max : i_cfg.boost_duty_max;
        v_lo = (n_mode == bbm_pkg::MODE_BUCK) ? i_cfg.buck_duty_min : i_cfg.boost_duty_min;
        if (v_duty > v_lo) begin
            v_duty = (v_duty < v_hi) ? v_duty : v_hi;
        end else begin
            v_duty = v_lo;
        end

        n_res.mode              = n_mode;
        n_res.drive_enable      = 1'b0;
        n_res.compares_valid    = 1'b0;
        n_res.buck_compare      = 16'd0;
        n_res.boost_compare     = 16'd0;
        n_res.adc_trigger_early = 16'd0;
        n_res.adc_trigger_late  = 16'd0;

        if (n_mode != bbm_pkg::MODE_SHUTDOWN) begin
            n_duty                  = v_duty;
            n_res.drive_enable      = 1'b1;
            n_res.compares_valid    = 1'b1;
            n_res.buck_compare      = (n_mode == bbm_pkg::MODE_BOOST) ? PERIOD_NEXT : v_duty;
            n_res.boost_compare     = (n_mode == bbm_pkg::MODE_BUCK) ? 16'd0 : v_duty;
            n_res.adc_trigger_early = v_duty >> 1;
            n_res.adc_trigger_late  = (v_duty < PERIOD_W)
                                    ? v_duty + ((PERIOD_W - v_duty) >> 1) : v_duty;
        end
        n_res.duty_value = n_duty;
    end

    // Converter state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= bbm_pkg::MODE_SHUTDOWN;
            r_band      <= bbm_pkg::BAND_CENTER_RST;
            r_duty      <= 16'd0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= i_valid;
            if (i_valid) begin
                r_mode <= n_mode;
                r_band <= n_band;
                r_duty <= n_duty;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

    // The pending result always reflects the held converter state.
    a_state_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.duty_value == r_duty) && (r_res.mode == r_mode))
        else $error("result does not match held converter state");

    // Enables follow the mode: off exactly in shutdown.
    a_enable_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.drive_enable == r_res.compares_valid)
                     && (r_res.drive_enable == (r_res.mode != bbm_pkg::MODE_SHUTDOWN)))
        else $error("drive enable inconsistent with mode");

    // Shutdown results carry cleared compares.
    a_shutdown_compares: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.mode == bbm_pkg::MODE_SHUTDOWN) |->
            (r_res.buck_compare == 16'd0) && (r_res.boost_compare == 16'd0)
            && (r_res.adc_trigger_early == 16'd0) && (r_res.adc_trigger_late == 16'd0))
        else $error("compares not cleared in shutdown");

    // Buck mode leaves the boost leg off.
    a_buck_leg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.mode == bbm_pkg::MODE_BUCK) |-> (r_res.boost_compare == 16'd0))
        else $error("boost compare active in buck mode");

endmodule
